// ===== sv/cbfc_pkg.sv =====
// shared types and constants of the clause buffer format checker
`default_nettype none
package cbfc_pkg;

   localparam int unsigned BUFFER_WORDS_DEF = 1048576;
   localparam int unsigned WORD_W           = 32;
   localparam int unsigned MAXW_W           = 21;
   localparam int unsigned POS_W            = 21;
   localparam int unsigned GLEN_W           = 21;
   localparam int unsigned CNT_W            = 31;
   localparam int unsigned CSR_ADDR_W       = 3;
   localparam int unsigned CSR_DATA_W       = 32;

   // register index taken from the word address
   localparam logic REG_MAX_WORDS = 1'b0;

   typedef enum logic [1:0] {
      SEC_PCOUNT,
      SEC_PCLAUSE,
      SEC_GCOUNT,
      SEC_GLITS
   } section_type;

   typedef enum logic [2:0] {
      ST_OK,
      ST_TOO_FULL,
      ST_PRIO_TRUNC,
      ST_EMPTY_CLAUSE,
      ST_PRIO_MISMATCH,
      ST_NEG_COUNT,
      ST_GROUP_TRUNC,
      ST_ZERO_LIT
   } status_type;

   typedef struct packed {
      logic               load;
      status_type         status;
      logic [POS_W-1:0]   position;
   } result_type;

endpackage
`default_nettype wire

// ===== sv/clause_buffer_format_checker_core.sv =====
// Clause buffer format checker, top level.
// A buffer streams in as 32-bit words on the req_ channel (req_word, req_last);
// a word moves at a clock edge with req_valid high and req_stall low. Words
// that are not marked last give no result; the last word of a buffer gives one
// result word on the rsp_ channel: rsp_status and rsp_error_position.
// csr_ is an apb-style port holding max_words at byte address 0 (zero means
// the buffer size limit only); write it only between buffers.
// A last word passes through the input register and then the result
// register, which raises rsp_valid.
// Throughput: one word per cycle while req_stall is low; the section update,
// including the group size multiply, is combinational between the input
// register and the result register.
// Stall: the result register holds while rsp_stall is high; words that are
// not last still flow, and req_stall rises only when a last word waits on a
// full result register that is stalled.
// Reset clears max_words, the section state and both valid flags; the next
// word after reset starts a new buffer.
`default_nettype none
module clause_buffer_format_checker_core #(
   parameter int unsigned BUFFER_WORDS = cbfc_pkg::BUFFER_WORDS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire logic signed [cbfc_pkg::WORD_W-1:0]  req_word,
   input  wire logic                                req_last,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      logic [2:0]                          rsp_status,
   output      logic [cbfc_pkg::POS_W-1:0]          rsp_error_position,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [cbfc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [cbfc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output      logic [cbfc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output      logic                                csr_pready
);

   logic                                in_valid_ff, in_valid_in;
   logic signed [cbfc_pkg::WORD_W-1:0]  in_word_ff, in_word_in;
   logic                                in_last_ff, in_last_in;
   logic                                accept;
   logic                                advance;
   logic                                out_full;
   logic [cbfc_pkg::MAXW_W-1:0]         max_words;
   cbfc_pkg::result_type                result;

   // a non-last word never needs the result register
   assign advance   = in_valid_ff && (!in_last_ff || !out_full || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = accept || (in_valid_ff && !advance);
      in_word_in  = in_word_ff;
      in_last_in  = in_last_ff;
      if (accept) begin
         in_word_in = req_word;
         in_last_in = req_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_word_ff <= in_word_in;
      in_last_ff <= in_last_in;
   end

   cbfc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .max_words   (max_words)
   );

   cbfc_parser #(
      .BUFFER_WORDS (BUFFER_WORDS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .word      (in_word_ff),
      .last      (in_last_ff),
      .max_words (max_words),
      .result    (result)
   );

   cbfc_rsp_reg u_rsp (
      .clock              (clock),
      .reset              (reset),
      .result             (result),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_error_position (rsp_error_position),
      .full               (out_full)
   );

`ifndef SYNTH
   // a new result appears only after a last word left the input register
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(advance && in_last_ff))
      else $error("result without a last word");

   // a pending result is never overwritten while the receiver stalls
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_full && rsp_stall) |-> !result.load)
      else $error("result overwritten under stall");

   // input side stalls only when a word is held
   a_stall_needs_word: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && in_last_ff))
      else $error("stall without a waiting last word");
`endif

endmodule
`default_nettype wire

// ===== sv/cbfc_csr.sv =====
// configuration register file with an apb-style port
`default_nettype none
module cbfc_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [cbfc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [cbfc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output      logic [cbfc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output      logic                                csr_pready,
   output      logic [cbfc_pkg::MAXW_W-1:0]         max_words
);

   logic [cbfc_pkg::MAXW_W-1:0] max_words_ff;
   logic [cbfc_pkg::MAXW_W-1:0] max_words_in;
   logic                        reg_sel;
   logic                        wr_en;

   // the low two address bits are ignored; the top address bit picks the register
   assign reg_sel = (csr_paddr[cbfc_pkg::CSR_ADDR_W-1] == cbfc_pkg::REG_MAX_WORDS);
   assign wr_en   = csr_psel && csr_penable && csr_pwrite && reg_sel;

   always_comb begin
      max_words_in = max_words_ff;
      if (wr_en) begin
         max_words_in = csr_pwdata[cbfc_pkg::MAXW_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_words_ff <= '0;
      end else begin
         max_words_ff <= max_words_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (reg_sel) begin
         csr_prdata = cbfc_pkg::CSR_DATA_W'(max_words_ff);
      end
   end

   assign csr_pready = 1'b1;
   assign max_words  = max_words_ff;

endmodule
`default_nettype wire

// ===== sv/cbfc_parser.sv =====
// section tracker: a word per cycle while step is high; first error kept, too-full wins
`default_nettype none
module cbfc_parser #(
   parameter int unsigned BUFFER_WORDS = cbfc_pkg::BUFFER_WORDS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                step,
   input  wire logic signed [cbfc_pkg::WORD_W-1:0]  word,
   input  wire logic                                last,
   input  wire logic [cbfc_pkg::MAXW_W-1:0]         max_words,
   output      cbfc_pkg::result_type                result
);

   localparam int unsigned IDX_W  = $clog2(BUFFER_WORDS + 1);
   localparam int unsigned CMP_W  = (IDX_W > cbfc_pkg::MAXW_W) ? IDX_W : cbfc_pkg::MAXW_W;
   localparam int unsigned PROD_W = cbfc_pkg::CNT_W + cbfc_pkg::GLEN_W;
   localparam logic [IDX_W-1:0]  BUF_LIMIT = IDX_W'(BUFFER_WORDS);
   localparam logic [cbfc_pkg::GLEN_W-1:0] GLEN_MAX = '1;

   cbfc_pkg::section_type             section_ff, section_in;
   cbfc_pkg::status_type              status_ff, status_in;
   logic [IDX_W-1:0]                  word_index_ff, word_index_in;
   logic [IDX_W-1:0]                  position_ff, position_in;
   logic [cbfc_pkg::CNT_W-1:0]        prio_target_ff, prio_target_in;
   logic [cbfc_pkg::CNT_W-1:0]        prio_done_ff, prio_done_in;
   logic                              clause_open_ff, clause_open_in;
   logic [cbfc_pkg::GLEN_W-1:0]       group_length_ff, group_length_in;
   logic [IDX_W-1:0]                  group_rem_ff, group_rem_in;

   logic [IDX_W-1:0]                  limit;
   logic                              neg;
   logic                              zero_word;
   logic [PROD_W-1:0]                 need_full;
   logic [IDX_W-1:0]                  need_sat;
   logic [IDX_W-1:0]                  rem_dec;
   logic [cbfc_pkg::CNT_W-1:0]        done_inc;

   // a limit of zero or above the buffer size means the buffer size
   always_comb begin
      if (max_words != '0 && CMP_W'(max_words) <= CMP_W'(BUFFER_WORDS)) begin
         limit = IDX_W'(max_words);
      end else begin
         limit = BUF_LIMIT;
      end
   end

   assign neg       = word[cbfc_pkg::WORD_W-1];
   assign zero_word = (word == '0);
   assign need_full = PROD_W'(word[cbfc_pkg::CNT_W-1:0]) * PROD_W'(group_length_ff);
   assign need_sat  = (need_full > PROD_W'(BUFFER_WORDS)) ? BUF_LIMIT : IDX_W'(need_full);
   assign rem_dec   = (group_rem_ff != '0) ? group_rem_ff - 1'b1 : group_rem_ff;
   assign done_inc  = prio_done_ff + 1'b1;

   always_comb begin
      section_in      = section_ff;
      status_in       = status_ff;
      word_index_in   = word_index_ff;
      position_in     = position_ff;
      prio_target_in  = prio_target_ff;
      prio_done_in    = prio_done_ff;
      clause_open_in  = clause_open_ff;
      group_length_in = group_length_ff;
      group_rem_in    = group_rem_ff;
      result.load     = 1'b0;
      result.status   = cbfc_pkg::ST_OK;
      result.position = '0;

      if (step) begin
         priority if (word_index_ff >= limit) begin
            if (status_ff != cbfc_pkg::ST_TOO_FULL) begin
               status_in   = cbfc_pkg::ST_TOO_FULL;
               position_in = word_index_ff;
            end
         end else if (status_ff == cbfc_pkg::ST_OK) begin
            unique case (section_ff)
               cbfc_pkg::SEC_PCOUNT: begin
                  if (neg) begin
                     status_in   = cbfc_pkg::ST_PRIO_MISMATCH;
                     position_in = word_index_ff;
                  end else if (zero_word) begin
                     section_in = cbfc_pkg::SEC_GCOUNT;
                  end else begin
                     prio_target_in = word[cbfc_pkg::CNT_W-1:0];
                     prio_done_in   = '0;
                     clause_open_in = 1'b0;
                     section_in     = cbfc_pkg::SEC_PCLAUSE;
                  end
               end
               cbfc_pkg::SEC_PCLAUSE: begin
                  if (zero_word) begin
                     if (!clause_open_ff) begin
                        status_in   = cbfc_pkg::ST_EMPTY_CLAUSE;
                        position_in = word_index_ff;
                     end else begin
                        prio_done_in   = done_inc;
                        clause_open_in = 1'b0;
                        // done counts up by one from zero, so reaching target is equality
                        if (done_inc == prio_target_ff) begin
                           section_in = cbfc_pkg::SEC_GCOUNT;
                        end
                     end
                  end else begin
                     clause_open_in = 1'b1;
                  end
               end
               cbfc_pkg::SEC_GCOUNT: begin
                  if (neg) begin
                     status_in   = cbfc_pkg::ST_NEG_COUNT;
                     position_in = word_index_ff;
                  end else begin
                     group_rem_in = need_sat;
                     if (need_sat == '0) begin
                        section_in = cbfc_pkg::SEC_GCOUNT;
                        if (group_length_ff != GLEN_MAX) begin
                           group_length_in = group_length_ff + 1'b1;
                        end
                     end else begin
                        section_in = cbfc_pkg::SEC_GLITS;
                     end
                  end
               end
               cbfc_pkg::SEC_GLITS: begin
                  if (zero_word) begin
                     status_in   = cbfc_pkg::ST_ZERO_LIT;
                     position_in = word_index_ff;
                  end else begin
                     group_rem_in = rem_dec;
                     if (rem_dec == '0) begin
                        section_in = cbfc_pkg::SEC_GCOUNT;
                        if (group_length_ff != GLEN_MAX) begin
                           group_length_in = group_length_ff + 1'b1;
                        end
                     end
                  end
               end
               default: begin
                  section_in = section_ff;
               end
            endcase
         end

         if (word_index_ff < BUF_LIMIT) begin
            word_index_in = word_index_ff + 1'b1;
         end

         if (last) begin
            // truncation only counts when nothing was latched before
            if (status_in == cbfc_pkg::ST_OK) begin
               if (section_in == cbfc_pkg::SEC_PCLAUSE) begin
                  status_in   = cbfc_pkg::ST_PRIO_TRUNC;
                  position_in = word_index_in;
               end else if (section_in == cbfc_pkg::SEC_GLITS) begin
                  status_in   = cbfc_pkg::ST_GROUP_TRUNC;
                  position_in = word_index_in;
               end
            end
            result.load     = 1'b1;
            result.status   = status_in;
            result.position = (status_in == cbfc_pkg::ST_OK) ?
                              cbfc_pkg::POS_W'(word_index_in) :
                              cbfc_pkg::POS_W'(position_in);
            // back to the reset state for the next buffer
            section_in      = cbfc_pkg::SEC_PCOUNT;
            status_in       = cbfc_pkg::ST_OK;
            word_index_in   = '0;
            position_in     = '0;
            prio_target_in  = '0;
            prio_done_in    = '0;
            clause_open_in  = 1'b0;
            group_length_in = cbfc_pkg::GLEN_W'(1);
            group_rem_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         section_ff      <= cbfc_pkg::SEC_PCOUNT;
         status_ff       <= cbfc_pkg::ST_OK;
         word_index_ff   <= '0;
         group_length_ff <= cbfc_pkg::GLEN_W'(1);
      end else begin
         section_ff      <= section_in;
         status_ff       <= status_in;
         word_index_ff   <= word_index_in;
         group_length_ff <= group_length_in;
      end
   end

   always_ff @(posedge clock) begin
      position_ff    <= position_in;
      prio_target_ff <= prio_target_in;
      prio_done_ff   <= prio_done_in;
      clause_open_ff <= clause_open_in;
      group_rem_ff   <= group_rem_in;
   end

endmodule
`default_nettype wire

// ===== sv/cbfc_rsp_reg.sv =====
// result output register with valid/stall handshake
`default_nettype none
module cbfc_rsp_reg (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire cbfc_pkg::result_type         result,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_stall,
   output      logic [2:0]                   rsp_status,
   output      logic [cbfc_pkg::POS_W-1:0]   rsp_error_position,
   output      logic                         full
);

   logic                         valid_ff, valid_in;
   cbfc_pkg::status_type         status_ff, status_in;
   logic [cbfc_pkg::POS_W-1:0]   position_ff, position_in;

   always_comb begin
      valid_in    = valid_ff && rsp_stall;
      status_in   = status_ff;
      position_in = position_ff;
      if (result.load) begin
         valid_in    = 1'b1;
         status_in   = result.status;
         position_in = result.position;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      position_ff <= position_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_error_position = position_ff;
   assign full               = valid_ff;

endmodule
`default_nettype wire
